/* hw/rtl/mcrq_pkg.sv */
// Shared types and constants for the multi-CPU ready queue scheduler.
`default_nettype none
package mcrq_pkg;

    typedef enum logic [1:0] {
        KIND_WAKE    = 2'd0,
        KIND_PREEMPT = 2'd1,
        KIND_YIELD   = 2'd2,
        KIND_TERM    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ACT_DISPATCH = 2'd0,
        ACT_IDLE     = 2'd1,
        ACT_FORCE    = 2'd2,
        ACT_OVERFLOW = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESCHED,
        ST_SCAN,
        ST_SHIFT,
        ST_FORCE
    } state_t;

    localparam logic [1:0] POLICY_FIFO = 2'd0;
    localparam logic [1:0] POLICY_RR   = 2'd1;
    localparam logic [1:0] POLICY_LRTF = 2'd2;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_SLICE  = 1'b1;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  cpu;
        logic        cpu_ok;
        logic [7:0]  proc;
        logic [15:0] rtime;
    } event_t;

    typedef struct packed {
        logic [1:0] policy;
        logic [7:0] slice;
    } cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/mcrq_ram.sv */
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module mcrq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/mcrq_front.sv */
// Front end: accepts scheduler events, decodes them and buffers two of them.
`default_nettype none
module mcrq_front
    import mcrq_pkg::*;
#(
    parameter int NUM_CPUS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic [7:0]  s_tuser,
    output logic             ev_valid,
    output event_t           ev_data,
    input  wire logic        ev_pop
);
    event_t     buf_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    event_t     dec;
    logic       push;

    always_comb
    begin
        dec.kind   = kind_t'(s_tuser[1:0]);
        dec.cpu    = s_tdata[2:0];
        dec.cpu_ok = ({1'b0, s_tdata[2:0]} < 4'(NUM_CPUS)) || (NUM_CPUS > 7);
        dec.proc   = s_tdata[10:3];
        dec.rtime  = s_tdata[26:11];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign ev_valid = (cnt_reg != 2'd0);
    assign ev_data  = buf_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = ev_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(ev_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/mcrq_back.sv */
// Back end: ready queue, CPU table, scan and shift sequencer, result register.
`default_nettype none
module mcrq_back
    import mcrq_pkg::*;
#(
    parameter int NUM_CPUS    = 8,
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  cfg_t        cfg,
    input  wire logic   ev_valid,
    input  event_t      ev_data,
    output logic        ev_pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output action_t     out_act,
    output logic [2:0]  out_cpu,
    output logic [7:0]  out_proc,
    output logic [7:0]  out_slice
);
    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int CPW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int FW  = $clog2(NUM_CPUS + 1);

    state_t      state_reg, state_next;
    event_t      ev_reg, ev_next;
    logic [CW-1:0] count_reg, count_next;
    logic        run_valid_reg [NUM_CPUS];
    logic        run_valid_next [NUM_CPUS];
    logic [7:0]  run_proc_reg [NUM_CPUS];
    logic [7:0]  run_proc_next [NUM_CPUS];
    logic [15:0] run_time_reg [NUM_CPUS];
    logic [15:0] run_time_next [NUM_CPUS];
    logic [CW-1:0] issue_reg, issue_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic [CW-1:0] didx_reg, didx_next;
    logic        dv_reg, dv_next;
    logic [CW-1:0] best_idx_reg, best_idx_next;
    logic [7:0]  best_proc_reg, best_proc_next;
    logic [15:0] best_time_reg, best_time_next;
    logic        best_ok_reg, best_ok_next;
    logic [FW-1:0] fcnt_reg, fcnt_next;
    logic [15:0] least_reg, least_next;
    logic [CPW-1:0] victim_reg, victim_next;
    logic        found_reg, found_next;
    logic        ov_reg, ov_next;
    action_t     oact_reg, oact_next;
    logic [2:0]  ocpu_reg, ocpu_next;
    logic [7:0]  oproc_reg, oproc_next;
    logic [7:0]  oslice_reg, oslice_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [23:0]   ram_wdata, ram_rdata;
    logic [CW-1:0] wtmp;
    logic          any_idle, full;
    logic [CPW-1:0] idle_idx, c;
    logic [7:0]    sl;

    mcrq_ram #(.WIDTH(24), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid = ov_reg;
    assign out_act   = oact_reg;
    assign out_cpu   = ocpu_reg;
    assign out_proc  = oproc_reg;
    assign out_slice = oslice_reg;

    always_comb
    begin
        any_idle = 1'b0;
        idle_idx = '0;
        for (int i = NUM_CPUS - 1; i >= 0; i--)
        begin
            if (!run_valid_reg[i])
            begin
                any_idle = 1'b1;
                idle_idx = CPW'(i);
            end
        end
    end

    assign full = (count_reg == CW'(QUEUE_DEPTH));
    assign sl   = (cfg.policy == POLICY_RR) ? cfg.slice : 8'd0;

    always_comb
    begin
        state_next     = state_reg;
        ev_next        = ev_reg;
        count_next     = count_reg;
        run_valid_next = run_valid_reg;
        run_proc_next  = run_proc_reg;
        run_time_next  = run_time_reg;
        issue_next     = issue_reg;
        lim_next       = lim_reg;
        didx_next      = didx_reg;
        dv_next        = dv_reg;
        best_idx_next  = best_idx_reg;
        best_proc_next = best_proc_reg;
        best_time_next = best_time_reg;
        best_ok_next   = best_ok_reg;
        fcnt_next      = fcnt_reg;
        least_next     = least_reg;
        victim_next    = victim_reg;
        found_next     = found_reg;
        ov_next        = ov_reg && !out_ready;
        oact_next      = oact_reg;
        ocpu_next      = ocpu_reg;
        oproc_next     = oproc_reg;
        oslice_next    = oslice_reg;
        ev_pop         = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = '0;
        ram_raddr      = issue_reg[AW-1:0];
        wtmp           = didx_reg - CW'(1);
        c              = CPW'(ev_reg.cpu);

        unique case (state_reg)
            ST_IDLE:
            begin
                // start an event only once the result register is empty
                if (ev_valid && !ov_reg)
                begin
                    ev_pop  = 1'b1;
                    ev_next = ev_data;
                    c       = CPW'(ev_data.cpu);
                    if (ev_data.kind == KIND_WAKE)
                    begin
                        if (any_idle)
                        begin
                            run_valid_next[idle_idx] = 1'b1;
                            run_proc_next[idle_idx]  = ev_data.proc;
                            run_time_next[idle_idx]  = ev_data.rtime;
                            ov_next     = 1'b1;
                            oact_next   = ACT_DISPATCH;
                            ocpu_next   = 3'(idle_idx);
                            oproc_next  = ev_data.proc;
                            oslice_next = sl;
                        end
                        else if (full)
                        begin
                            ov_next     = 1'b1;
                            oact_next   = ACT_OVERFLOW;
                            ocpu_next   = 3'd0;
                            oproc_next  = ev_data.proc;
                            oslice_next = 8'd0;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = {ev_data.proc, ev_data.rtime};
                            count_next = count_reg + CW'(1);
                            if (cfg.policy == POLICY_LRTF)
                            begin
                                fcnt_next   = '0;
                                least_next  = ev_data.rtime;
                                victim_next = '0;
                                found_next  = 1'b0;
                                state_next  = ST_FORCE;
                            end
                        end
                    end
                    else if (ev_data.cpu_ok)
                    begin
                        if (ev_data.kind == KIND_PREEMPT && run_valid_reg[c])
                        begin
                            if (full)
                            begin
                                run_time_next[c] = ev_data.rtime;
                                ov_next     = 1'b1;
                                oact_next   = ACT_OVERFLOW;
                                ocpu_next   = ev_data.cpu;
                                oproc_next  = run_proc_reg[c];
                                oslice_next = 8'd0;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_wdata  = {run_proc_reg[c], ev_data.rtime};
                                count_next = count_reg + CW'(1);
                                state_next = ST_RESCHED;
                            end
                        end
                        else
                        begin
                            state_next = ST_RESCHED;
                        end
                    end
                end
            end

            ST_RESCHED:
            begin
                if (count_reg == '0)
                begin
                    run_valid_next[c] = 1'b0;
                    run_proc_next[c]  = 8'd0;
                    run_time_next[c]  = 16'd0;
                    ov_next     = 1'b1;
                    oact_next   = ACT_IDLE;
                    ocpu_next   = ev_reg.cpu;
                    oproc_next  = 8'd0;
                    oslice_next = 8'd0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    issue_next   = '0;
                    dv_next      = 1'b0;
                    best_ok_next = 1'b0;
                    lim_next     = (cfg.policy == POLICY_LRTF) ? count_reg : CW'(1);
                    state_next   = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // one read issued per cycle, data compared in the next cycle
                dv_next = issue_reg < lim_reg;
                if (issue_reg < lim_reg)
                begin
                    issue_next = issue_reg + CW'(1);
                    didx_next  = issue_reg;
                end
                if (dv_reg && (!best_ok_reg || ram_rdata[15:0] > best_time_reg))
                begin
                    best_ok_next   = 1'b1;
                    best_idx_next  = didx_reg;
                    best_proc_next = ram_rdata[23:16];
                    best_time_next = ram_rdata[15:0];
                end
                if (issue_reg >= lim_reg && !dv_reg)
                begin
                    issue_next = best_idx_reg + CW'(1);
                    dv_next    = 1'b0;
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                // close the gap: entry k+1 moves to k, one per cycle
                dv_next = issue_reg < count_reg;
                if (issue_reg < count_reg)
                begin
                    issue_next = issue_reg + CW'(1);
                    didx_next  = issue_reg;
                end
                if (dv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wtmp[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (issue_reg >= count_reg && !dv_reg)
                begin
                    count_next        = count_reg - CW'(1);
                    run_valid_next[c] = 1'b1;
                    run_proc_next[c]  = best_proc_reg;
                    run_time_next[c]  = best_time_reg;
                    ov_next     = 1'b1;
                    oact_next   = ACT_DISPATCH;
                    ocpu_next   = ev_reg.cpu;
                    oproc_next  = best_proc_reg;
                    oslice_next = sl;
                    state_next  = ST_IDLE;
                end
            end

            ST_FORCE:
            begin
                if (fcnt_reg < FW'(NUM_CPUS))
                begin
                    if (run_time_reg[fcnt_reg[CPW-1:0]] < least_reg)
                    begin
                        least_next  = run_time_reg[fcnt_reg[CPW-1:0]];
                        victim_next = fcnt_reg[CPW-1:0];
                        found_next  = 1'b1;
                    end
                    fcnt_next = fcnt_reg + FW'(1);
                end
                else
                begin
                    if (found_reg)
                    begin
                        ov_next     = 1'b1;
                        oact_next   = ACT_FORCE;
                        ocpu_next   = 3'(victim_reg);
                        oproc_next  = 8'd0;
                        oslice_next = 8'd0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ev_reg        <= ev_next;
        lim_reg       <= lim_next;
        didx_reg      <= didx_next;
        best_idx_reg  <= best_idx_next;
        best_proc_reg <= best_proc_next;
        best_time_reg <= best_time_next;
        least_reg     <= least_next;
        victim_reg    <= victim_next;
        oact_reg      <= oact_next;
        ocpu_reg      <= ocpu_next;
        oproc_reg     <= oproc_next;
        oslice_reg    <= oslice_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            dv_reg      <= 1'b0;
            best_ok_reg <= 1'b0;
            fcnt_reg    <= '0;
            found_reg   <= 1'b0;
            ov_reg      <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                run_valid_reg[i] <= 1'b0;
                run_proc_reg[i]  <= 8'd0;
                run_time_reg[i]  <= 16'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            dv_reg        <= dv_next;
            best_ok_reg   <= best_ok_next;
            fcnt_reg      <= fcnt_next;
            found_reg     <= found_next;
            ov_reg        <= ov_next;
            run_valid_reg <= run_valid_next;
            run_proc_reg  <= run_proc_next;
            run_time_reg  <= run_time_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/multi_cpu_ready_queue_scheduler.sv */
// Top level of the multi-CPU ready queue scheduler.
//
// Scheduler events (wake up, preempt, yield, terminate) enter on the s_ stream
// and are buffered two deep by the front end, so the input can take up to two
// events while a result waits on the m_ stream. The back end handles one event
// at a time and produces zero or one result request per event. A wake-up to an
// idle CPU, an overflow, or an ignored event needs no scan; a queued wake-up in
// longest-remaining mode adds a least-time scan over all CPUs; a reschedule
// scans the head entry in FIFO/round robin or the whole queue fill in
// longest-remaining mode (one ready-queue RAM read per cycle), then moves the
// tail after the removed entry down one entry per cycle through the same RAM.
// The ready queue lives in one RAM whose entries are only read once written,
// so no clearing pass runs after reset. Configuration writes are always
// accepted and must only happen while the block is idle.
`default_nettype none
module multi_cpu_ready_queue_scheduler
    import mcrq_pkg::*;
#(
    parameter int NUM_CPUS    = 8,
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // event requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // cpu_index[2:0], proc_id[10:3], remaining_time[26:11]
    input  wire logic [7:0]  s_tuser,   // kind[1:0]
    // result requests
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // target_cpu[2:0], chosen_proc[10:3], granted_slice[18:11]
    output logic [7:0]       m_tuser,   // action[1:0]
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index, // 0 policy_mode, 1 slice_length
    input  wire logic [7:0]  cfg_data
);
    cfg_t    cfg_reg;
    event_t  ev_data;
    logic    ev_valid, ev_pop;
    action_t out_act;
    logic [2:0] out_cpu;
    logic [7:0] out_proc, out_slice;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POLICY: cfg_reg.policy <= cfg_data[1:0];
                CFG_SLICE:  cfg_reg.slice  <= cfg_data;
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    mcrq_front #(.NUM_CPUS(NUM_CPUS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .ev_valid (ev_valid),
        .ev_data  (ev_data),
        .ev_pop   (ev_pop)
    );

    mcrq_back #(.NUM_CPUS(NUM_CPUS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ev_valid  (ev_valid),
        .ev_data   (ev_data),
        .ev_pop    (ev_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_act   (out_act),
        .out_cpu   (out_cpu),
        .out_proc  (out_proc),
        .out_slice (out_slice)
    );

    assign m_tdata = {5'd0, out_slice, out_proc, out_cpu};
    assign m_tuser = {6'd0, out_act};
endmodule
`default_nettype wire

/* hw/rtl/mcrq_checker.sv */
// Port-level checks for the scheduler, bound to the top level.
`default_nettype none
module mcrq_checker
    import mcrq_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [7:0]  m_tuser
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == ACT_IDLE |-> m_tdata[18:3] == 16'd0)
        else $error("idle dispatch carries a process or slice");

    a_force: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == ACT_FORCE |-> m_tdata[18:3] == 16'd0)
        else $error("force preempt carries a process or slice");

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == ACT_OVERFLOW |-> m_tdata[18:11] == 8'd0)
        else $error("overflow carries a slice");
endmodule

bind multi_cpu_ready_queue_scheduler mcrq_checker u_mcrq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

/* sim/multi_cpu_ready_queue_scheduler_test.sv */
// Self-checking testbench for the multi-CPU ready queue scheduler.
`default_nettype none
module multi_cpu_ready_queue_scheduler_test;
    import mcrq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCPU       = 8;
    localparam int QDEPTH     = 32;
    localparam int DRAIN_WAIT = 120;    // above the worst-case event cost
    localparam int WD_LIMIT   = 20000;  // cycles with no request moving on any channel
    localparam int LONG_HOLD  = 400;    // receiver hold-off, enough to back up the input

    typedef struct {
        kind_t       kind;
        logic [2:0]  cpu;
        logic [7:0]  proc;
        logic [15:0] rtime;
    } sched_event_t;

    typedef struct {
        action_t    action;
        logic [2:0] cpu;
        logic [7:0] proc;
        logic [7:0] slice;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [7:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = '0;

    multi_cpu_ready_queue_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow of the scheduler state, advanced once per accepted event
    logic [7:0]  q_proc [QDEPTH];
    logic [15:0] q_time [QDEPTH];
    int          q_count;
    logic        cpu_busy [NCPU];
    logic [7:0]  cpu_proc [NCPU];
    logic [15:0] cpu_time [NCPU];
    logic [1:0]  policy;
    logic [7:0]  slice_len;

    sched_event_t  pending_events[$];
    sched_result_t expected_results[$];

    int  errors = 0;
    int  n_events = 0;
    int  n_results = 0;
    int  n_overflow = 0;
    int  n_force = 0;
    int  n_idle = 0;
    logic quiet = 1'b0;       // no idling on either side near the end
    int  hold_token = 0;      // bumped to ask the receiver for one long hold-off
    logic moved;              // some request moved this cycle (watchdog)

    function automatic logic [7:0] grant_slice();
        return (policy == POLICY_RR) ? slice_len : 8'd0;
    endfunction

    // Give a CPU the next queued process, or leave it idle
    function automatic sched_result_t dispatch_next(logic [2:0] cpu);
        sched_result_t r;
        int pick;
        pick = 0;
        if (q_count == 0)
        begin
            cpu_busy[cpu] = 1'b0;
            cpu_proc[cpu] = '0;
            cpu_time[cpu] = '0;
            r = '{ACT_IDLE, cpu, 8'd0, 8'd0};
            return r;
        end
        if (policy == POLICY_LRTF)
            for (int i = 1; i < q_count; i++)
                if (q_time[i] > q_time[pick])
                    pick = i;   // strict compare: the entry nearest the head wins a tie
        cpu_busy[cpu] = 1'b1;
        cpu_proc[cpu] = q_proc[pick];
        cpu_time[cpu] = q_time[pick];
        for (int i = pick; i + 1 < q_count; i++)
        begin
            q_proc[i] = q_proc[i + 1];
            q_time[i] = q_time[i + 1];
        end
        q_count--;
        r = '{ACT_DISPATCH, cpu, cpu_proc[cpu], grant_slice()};
        return r;
    endfunction

    // Advance the shadow state by one event; returns 1 when a result is due
    function automatic bit schedule_event(sched_event_t ev, output sched_result_t r);
        logic [15:0] least;
        int victim;
        r = '{ACT_IDLE, 3'd0, 8'd0, 8'd0};
        if (ev.kind == KIND_WAKE)
        begin
            for (int i = 0; i < NCPU; i++)
                if (!cpu_busy[i])
                begin
                    cpu_busy[i] = 1'b1;
                    cpu_proc[i] = ev.proc;
                    cpu_time[i] = ev.rtime;
                    r = '{ACT_DISPATCH, 3'(i), ev.proc, grant_slice()};
                    return 1'b1;
                end
            if (q_count >= QDEPTH)
            begin
                r = '{ACT_OVERFLOW, 3'd0, ev.proc, 8'd0};
                return 1'b1;
            end
            q_proc[q_count] = ev.proc;
            q_time[q_count] = ev.rtime;
            q_count++;
            if (policy != POLICY_LRTF)
                return 1'b0;
            least = ev.rtime;
            victim = -1;
            for (int i = 0; i < NCPU; i++)
                if (cpu_time[i] < least)
                begin
                    least = cpu_time[i];
                    victim = i;
                end
            if (victim < 0)
                return 1'b0;
            r = '{ACT_FORCE, 3'(victim), 8'd0, 8'd0};
            return 1'b1;
        end
        if (ev.kind == KIND_PREEMPT && cpu_busy[ev.cpu])
        begin
            if (q_count >= QDEPTH)
            begin
                // queue full: CPU keeps its process, time refreshed
                cpu_time[ev.cpu] = ev.rtime;
                r = '{ACT_OVERFLOW, ev.cpu, cpu_proc[ev.cpu], 8'd0};
                return 1'b1;
            end
            q_proc[q_count] = cpu_proc[ev.cpu];
            q_time[q_count] = ev.rtime;
            q_count++;
        end
        r = dispatch_next(ev.cpu);
        return 1'b1;
    endfunction

    // Sender: feeds pending events, random gap bursts, predicts on acceptance
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t r;
        sched_event_t ev;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                ev.kind  = kind_t'(s_tuser[1:0]);
                ev.cpu   = s_tdata[2:0];
                ev.proc  = s_tdata[10:3];
                ev.rtime = s_tdata[26:11];
                n_events++;
                if (schedule_event(ev, r))
                    expected_results.push_back(r);
            end
            if (s_tvalid && !s_tready)
                ;   // hold the offered request
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_events.size() > 0 && !quiet && $urandom_range(0, 9) == 0)
            begin
                send_gap <= $urandom_range(1, 18) - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_events.size() > 0)
            begin
                ev = pending_events.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'd0, ev.rtime, ev.proc, ev.cpu};
                s_tuser  <= {6'd0, ev.kind};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls plus one long hold-off on request, checks results
    int stall_left = 0;
    int hold_seen = 0;
    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t exp_r;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result action=%0d cpu=%0d proc=%0d slice=%0d",
                             $time, m_tuser[1:0], m_tdata[2:0], m_tdata[10:3], m_tdata[18:11]);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_tuser[1:0] !== exp_r.action || m_tdata[2:0] !== exp_r.cpu
                        || m_tdata[10:3] !== exp_r.proc || m_tdata[18:11] !== exp_r.slice)
                    begin
                        errors++;
                        $display("%0t: mismatch expected action=%0d cpu=%0d proc=%0d slice=%0d",
                                 $time, exp_r.action, exp_r.cpu, exp_r.proc, exp_r.slice);
                        $display("%0t:          actual   action=%0d cpu=%0d proc=%0d slice=%0d",
                                 $time, m_tuser[1:0], m_tdata[2:0], m_tdata[10:3],
                                 m_tdata[18:11]);
                    end
                    if (exp_r.action == ACT_OVERFLOW) n_overflow++;
                    if (exp_r.action == ACT_FORCE)    n_force++;
                    if (exp_r.action == ACT_IDLE)     n_idle++;
                end
            end
            if (hold_token != hold_seen)
            begin
                hold_seen  <= hold_token;
                stall_left <= LONG_HOLD;
                m_tready   <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(1, 18) - 1;
                m_tready   <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: too long with nothing moving on any channel
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        moved = (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready);
        if (moved || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WD_LIMIT)
        begin
            $display("%0t: no progress, %0d results outstanding", $time,
                     expected_results.size());
            $display("multi_cpu_ready_queue_scheduler_test: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic add_event(kind_t k, logic [2:0] cpu, logic [7:0] proc, logic [15:0] t);
        sched_event_t ev;
        ev = '{k, cpu, proc, t};
        pending_events.push_back(ev);
    endtask

    // Block until every event is taken and answered, then let trailing work settle
    task automatic wait_drained();
        do @(posedge clk);
        while (pending_events.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_POLICY)
            policy = value[1:0];
        else
            slice_len = value;
        @(posedge clk);
    endtask

    // Random events; wake_pct steers between filling and draining the queue
    task automatic add_random(int count, int wake_pct);
        kind_t k;
        logic [15:0] t;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < wake_pct)
                k = KIND_WAKE;
            else
                k = kind_t'($urandom_range(1, 3));
            // narrow times now and then so that LRTF ties and equal times show up
            t = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
            add_event(k, 3'($urandom_range(0, 7)), 8'($urandom), t);
        end
    endtask

    initial
    begin
        q_count = 0;
        policy = POLICY_FIFO;
        slice_len = '0;
        for (int i = 0; i < NCPU; i++)
        begin
            cpu_busy[i] = 1'b0;
            cpu_proc[i] = '0;
            cpu_time[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: FIFO at reset defaults
        add_event(KIND_YIELD, 3'd7, 8'd0, 16'd0);           // idle CPU, empty queue
        add_event(KIND_WAKE, 3'd0, 8'd0, 16'd0);
        add_event(KIND_WAKE, 3'd5, 8'd255, 16'hFFFF);
        for (int i = 0; i < 7; i++)
            add_event(KIND_WAKE, 3'(i), 8'(10 + i), 16'(100 * i));
        add_event(KIND_PREEMPT, 3'd0, 8'd0, 16'd1);         // queue then redispatch
        add_event(KIND_YIELD, 3'd1, 8'd0, 16'd0);
        add_event(KIND_TERM, 3'd7, 8'hAA, 16'h5555);
        add_event(KIND_TERM, 3'd2, 8'd0, 16'd0);
        add_event(KIND_PREEMPT, 3'd2, 8'd0, 16'd0);         // preempt of an idle CPU
        wait_drained();

        // Directed: LRTF force preempt, then a tie, then round robin slice
        write_reg(CFG_POLICY, {6'h3F, POLICY_LRTF});
        add_event(KIND_WAKE, 3'd0, 8'd50, 16'hFFFF);
        add_event(KIND_WAKE, 3'd0, 8'd51, 16'd0);
        add_event(KIND_WAKE, 3'd0, 8'd52, 16'hFFFF);
        add_event(KIND_TERM, 3'd3, 8'd0, 16'd0);
        add_event(KIND_PREEMPT, 3'd4, 8'd0, 16'hFFFF);
        wait_drained();
        write_reg(CFG_POLICY, {6'h00, POLICY_RR});
        write_reg(CFG_SLICE, 8'hFF);
        add_event(KIND_YIELD, 3'd5, 8'd0, 16'd0);
        add_event(KIND_WAKE, 3'd0, 8'd60, 16'd7);
        wait_drained();

        // Random phases over several settings, extremes included
        write_reg(CFG_SLICE, 8'h00);
        add_random(130, 75);                  // fill the queue up to overflow
        hold_token <= hold_token + 1;         // long receiver hold-off early in this phase
        wait_drained();

        write_reg(CFG_POLICY, {6'h15, POLICY_LRTF});
        add_random(130, 70);
        wait_drained();

        write_reg(CFG_POLICY, {6'h2A, 2'd3});   // unused code, runs as FIFO
        write_reg(CFG_SLICE, 8'($urandom_range(1, 254)));
        add_random(120, 40);
        wait_drained();

        write_reg(CFG_POLICY, {6'h00, POLICY_RR});
        add_random(130, 65);
        wait_drained();

        write_reg(CFG_POLICY, {6'h00, POLICY_FIFO});
        write_reg(CFG_SLICE, 8'h80);
        add_random(130, 60);
        wait_drained();

        write_reg(CFG_POLICY, {6'h00, POLICY_LRTF});
        quiet <= 1'b1;
        add_random(130, 60);
        wait_drained();

        $display("Covered %0d events under FIFO, round robin, LRTF and the spare policy code;",
                 n_events);
        $display("%0d results: %0d idle dispatches, %0d force preempts, %0d overflows.",
                 n_results, n_idle, n_force, n_overflow);
        if (errors == 0 && expected_results.size() == 0)
            $display("multi_cpu_ready_queue_scheduler_test: PASS");
        else
            $display("multi_cpu_ready_queue_scheduler_test: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
